@@ sv/bpwm_pkg.sv @@
package bpwm_pkg;

  // Default width of the breathing ramp duty register.
  localparam int DutyWidthDefault = 16;

  // Configuration port geometry.
  localparam int CfgIndexWidth = 3;
  localparam int CfgDataWidth  = 16;

  // Register indexes on the configuration port.
  typedef enum logic [CfgIndexWidth-1:0] {
    REG_PERIOD         = 3'd0,
    REG_DUTY_MAX       = 3'd1,
    REG_DUTY_MIN       = 3'd2,
    REG_RESPONSE       = 3'd3,
    REG_BREATHE_ENABLE = 3'd4,
    REG_FIXED_DUTY     = 3'd5
  } reg_index_t;

  // Reset values of the configuration registers.
  localparam logic [15:0] PeriodReset        = 16'd100;
  localparam logic [15:0] DutyMaxReset       = 16'd100;
  localparam logic [15:0] DutyMinReset       = 16'd0;
  localparam logic [7:0]  ResponseReset      = 8'd1;
  localparam logic        BreatheEnableReset = 1'b1;
  localparam logic [15:0] FixedDutyReset     = 16'd0;

  // Configuration registers as seen by the datapath.
  typedef struct packed {
    logic [15:0] period;
    logic [15:0] duty_max;
    logic [15:0] duty_min;
    logic [7:0]  response;
    logic        breathe_enable;
    logic [15:0] fixed_duty;
  } cfg_t;

  // Input beat.
  typedef struct packed {
    logic ramp_tick;
    logic pwm_tick;
  } in_t;

  // Result beat.
  typedef struct packed {
    logic        pwm_level;
    logic [15:0] duty_now;
  } out_t;

endpackage

@@ sv/breathing_pwm_generator_core.sv @@
// Channel | Direction | Handshake             | Beat contents
// in      | input     | in_valid / in_ready   | in_data: ramp_tick, pwm_tick
// out     | output    | out_valid / out_ready | out_data: pwm_level, duty_now
// cfg     | input     | cfg_write             | cfg_index, cfg_data
//
// A beat is held in the input register while the ramp and counter logic work on
// it, and moves into the result register when that register is free or being
// drained; one beat per cycle is sustained while the output is not stalled,
// because the ramp and counter state update in the same cycle as the beat moves.
// Reset is synchronous and clears all control and ramp state.
// A stalled output holds the result; the input register takes a beat when it is
// empty, or when its held beat moves into a result register that is free or
// being drained in that cycle.
module breathing_pwm_generator_core #(
  parameter int DUTY_WIDTH = bpwm_pkg::DutyWidthDefault
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  bpwm_pkg::in_t                      in_data,
  output logic                               out_valid,
  input  logic                               out_ready,
  output bpwm_pkg::out_t                     out_data,
  input  logic                               cfg_write,
  input  logic [bpwm_pkg::CfgIndexWidth-1:0] cfg_index,
  input  logic [bpwm_pkg::CfgDataWidth-1:0]  cfg_data
);

  localparam int ExtWidth = DUTY_WIDTH + 16;

  bpwm_pkg::cfg_t        cfg;
  bpwm_pkg::in_t         stage;
  logic                  stage_valid;
  logic                  advance;
  logic                  ramp_step;
  logic [DUTY_WIDTH-1:0] ramp_duty_after;
  logic [DUTY_WIDTH-1:0] eff_duty;
  logic [ExtWidth-1:0]   fixed_ext;
  logic [ExtWidth-1:0]   eff_ext;
  logic                  level_after;

  bpwm_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // The held beat is processed when the result register can take it.
  assign advance  = stage_valid && (!out_valid || out_ready);
  assign in_ready = !stage_valid || advance;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (in_ready) begin
      stage_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      stage <= in_data;
    end
  end

  assign ramp_step = advance && cfg.breathe_enable && stage.ramp_tick;

  bpwm_ramp #(
    .DUTY_WIDTH (DUTY_WIDTH)
  ) u_ramp (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .step       (ramp_step),
    .duty_after (ramp_duty_after)
  );

  // Effective duty: ramp output, or the fixed duty cut to the ramp width.
  always_comb begin
    fixed_ext = {{DUTY_WIDTH{1'b0}}, cfg.fixed_duty};
    eff_duty  = cfg.breathe_enable ? ramp_duty_after : fixed_ext[DUTY_WIDTH-1:0];
    eff_ext   = {16'd0, eff_duty};
  end

  bpwm_pwm #(
    .DUTY_WIDTH (DUTY_WIDTH)
  ) u_pwm (
    .clk         (clk),
    .rst         (rst),
    .period      (cfg.period),
    .tick        (advance && stage.pwm_tick),
    .duty        (eff_duty),
    .level_after (level_after)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data.pwm_level <= level_after;
      out_data.duty_now  <= eff_ext[15:0];
    end
  end

  // A processed beat always shows up as a result in the next cycle.
  a_advance_gives_result: assert property (@(posedge clk) disable iff (rst)
    advance |=> out_valid)
    else $error("processed beat produced no result");

  // A held beat that cannot move on stays held.
  a_stage_kept: assert property (@(posedge clk) disable iff (rst)
    (stage_valid && !advance) |=> stage_valid)
    else $error("held input beat was lost");

  // A PWM tick with zero duty drives the output low.
  a_zero_duty_low: assert property (@(posedge clk) disable iff (rst)
    (advance && stage.pwm_tick && (eff_duty == '0)) |=> !out_data.pwm_level)
    else $error("output high with zero duty");

  // The result register is empty in the cycle after reset.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result present after reset");

endmodule

@@ sv/bpwm_cfg_regs.sv @@
module bpwm_cfg_regs (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_write,
  input  logic [bpwm_pkg::CfgIndexWidth-1:0]   cfg_index,
  input  logic [bpwm_pkg::CfgDataWidth-1:0]    cfg_data,
  output bpwm_pkg::cfg_t                       cfg
);

  // Register file; writes to unused indexes are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.period         <= bpwm_pkg::PeriodReset;
      cfg.duty_max       <= bpwm_pkg::DutyMaxReset;
      cfg.duty_min       <= bpwm_pkg::DutyMinReset;
      cfg.response       <= bpwm_pkg::ResponseReset;
      cfg.breathe_enable <= bpwm_pkg::BreatheEnableReset;
      cfg.fixed_duty     <= bpwm_pkg::FixedDutyReset;
    end else if (cfg_write) begin
      case (bpwm_pkg::reg_index_t'(cfg_index))
        bpwm_pkg::REG_PERIOD:         cfg.period         <= cfg_data;
        bpwm_pkg::REG_DUTY_MAX:       cfg.duty_max       <= cfg_data;
        bpwm_pkg::REG_DUTY_MIN:       cfg.duty_min       <= cfg_data;
        bpwm_pkg::REG_RESPONSE:       cfg.response       <= cfg_data[7:0];
        bpwm_pkg::REG_BREATHE_ENABLE: cfg.breathe_enable <= cfg_data[0];
        bpwm_pkg::REG_FIXED_DUTY:     cfg.fixed_duty     <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

@@ sv/bpwm_ramp.sv @@
module bpwm_ramp #(
  parameter int DUTY_WIDTH = bpwm_pkg::DutyWidthDefault
) (
  input  logic                  clk,
  input  logic                  rst,
  input  bpwm_pkg::cfg_t        cfg,
  input  logic                  step,
  output logic [DUTY_WIDTH-1:0] duty_after
);

  localparam int CmpWidth = DUTY_WIDTH + 16;

  logic [DUTY_WIDTH-1:0] ramp_duty;
  logic [DUTY_WIDTH-1:0] ramp_duty_next;
  logic [7:0]            ramp_prescale;
  logic [7:0]            ramp_prescale_next;
  logic                  falling;
  logic                  falling_next;

  logic [7:0]            prescale_inc;
  logic [DUTY_WIDTH-1:0] duty_inc;
  logic [DUTY_WIDTH-1:0] duty_dec;
  logic [CmpWidth-1:0]   inc_ext;
  logic [CmpWidth-1:0]   dec_ext;
  logic [CmpWidth-1:0]   cur_ext;
  logic [CmpWidth-1:0]   max_ext;
  logic [CmpWidth-1:0]   min_ext;

  // Operands widened so that any duty width compares against 16-bit limits.
  always_comb begin
    prescale_inc = ramp_prescale + 8'd1;
    duty_inc     = ramp_duty + {{(DUTY_WIDTH-1){1'b0}}, 1'b1};
    duty_dec     = ramp_duty - {{(DUTY_WIDTH-1){1'b0}}, 1'b1};
    inc_ext      = {16'd0, duty_inc};
    dec_ext      = {16'd0, duty_dec};
    cur_ext      = {16'd0, ramp_duty};
    max_ext      = {{DUTY_WIDTH{1'b0}}, cfg.duty_max};
    min_ext      = {{DUTY_WIDTH{1'b0}}, cfg.duty_min};
  end

  // Prescaler and triangular duty step.
  always_comb begin
    ramp_prescale_next = ramp_prescale;
    ramp_duty_next     = ramp_duty;
    falling_next       = falling;
    if (step) begin
      if (prescale_inc < cfg.response) begin
        ramp_prescale_next = prescale_inc;
      end else begin
        ramp_prescale_next = 8'd0;
        if (!falling) begin
          ramp_duty_next = duty_inc;
          if (inc_ext >= max_ext) begin
            falling_next = 1'b1;
          end
        end else if (cur_ext > min_ext) begin
          ramp_duty_next = duty_dec;
          if (dec_ext == min_ext) begin
            falling_next   = 1'b0;
            ramp_duty_next = '0;
          end
        end else begin
          falling_next   = 1'b0;
          ramp_duty_next = '0;
        end
      end
    end
  end

  assign duty_after = ramp_duty_next;

  // Ramp state.
  always_ff @(posedge clk) begin
    if (rst) begin
      ramp_duty     <= '0;
      ramp_prescale <= 8'd0;
      falling       <= 1'b0;
    end else begin
      ramp_duty     <= ramp_duty_next;
      ramp_prescale <= ramp_prescale_next;
      falling       <= falling_next;
    end
  end

endmodule

@@ sv/bpwm_pwm.sv @@
module bpwm_pwm #(
  parameter int DUTY_WIDTH = bpwm_pkg::DutyWidthDefault
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic [15:0]           period,
  input  logic                  tick,
  input  logic [DUTY_WIDTH-1:0] duty,
  output logic                  level_after
);

  localparam int CmpWidth = DUTY_WIDTH + 16;

  logic [15:0]         pwm_count;
  logic [15:0]         pwm_count_next;
  logic                level_reg;
  logic                level_reg_next;
  logic [15:0]         count_step;
  logic [CmpWidth-1:0] count_ext;
  logic [CmpWidth-1:0] duty_ext;

  // Counter runs 1..period; a zero duty parks it at zero with the output low.
  always_comb begin
    count_step     = (pwm_count >= period) ? 16'd1 : pwm_count + 16'd1;
    count_ext      = {{DUTY_WIDTH{1'b0}}, count_step};
    duty_ext       = {16'd0, duty};
    pwm_count_next = pwm_count;
    level_reg_next = level_reg;
    if (tick) begin
      if (duty == '0) begin
        pwm_count_next = 16'd0;
        level_reg_next = 1'b0;
      end else begin
        pwm_count_next = count_step;
        level_reg_next = (count_ext <= duty_ext);
      end
    end
  end

  assign level_after = level_reg_next;

  // Counter and output level state.
  always_ff @(posedge clk) begin
    if (rst) begin
      pwm_count <= 16'd0;
      level_reg <= 1'b0;
    end else begin
      pwm_count <= pwm_count_next;
      level_reg <= level_reg_next;
    end
  end

endmodule
